/* hdl/rwps_pkg.sv */
package rwps_pkg;

   // Defaults for the top-level parameters
   localparam int POP_MAX_DEF      = 64;
   localparam int FITNESS_BITS_DEF = 24;
   localparam int TAG_BITS_DEF     = 16;

   // Fixed field widths
   localparam int INDEX_BITS = 6;
   localparam int PSIZE_BITS = 7;

   // Population size after reset
   localparam logic [PSIZE_BITS-1:0] PSIZE_RESET = PSIZE_BITS'(64);

   // Action codes
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_OFFER = 1'b1;

endpackage

/* hdl/replace_worst_population_slot.sv */
// Population table with replace-worst insertion. A load transaction writes one
// entry (fitness and tag) and registers its result in the next cycle. An offer
// transaction scans the first population_size entries through the single read
// port of the table, one entry per cycle, keeping the lowest fitness (lowest
// index on ties). Its result is registered in the DECIDE state that follows the
// scan, where the scan length is population_size clamped to 1..POP_MAX, and the
// next transaction can be taken once the block is back in IDLE. The incomer
// replaces the worst entry if its fitness is strictly greater. One transaction
// is processed at a time; a request is taken only while the output register is
// empty or is being read in the same cycle. Reading a slot that was never
// loaded gives undefined contents.
// The population_size register may be written at any idle time.
module replace_worst_population_slot
   import rwps_pkg::*;
#(
   parameter int POP_MAX      = POP_MAX_DEF,
   parameter int FITNESS_BITS = FITNESS_BITS_DEF,
   parameter int TAG_BITS     = TAG_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [PSIZE_BITS-1:0]          csr_population_size,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_action,
   input  logic [INDEX_BITS-1:0]          req_entry_index,
   input  logic signed [FITNESS_BITS-1:0] req_fitness_value,
   input  logic [TAG_BITS-1:0]            req_member_tag,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_replaced,
   output logic [INDEX_BITS-1:0]          rsp_slot,
   output logic [TAG_BITS-1:0]            rsp_evicted_tag
);

   localparam int AW = (POP_MAX > 1) ? $clog2(POP_MAX) : 1;
   localparam int CW = $clog2(POP_MAX + 1);
   localparam int EW = FITNESS_BITS + TAG_BITS;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   // Table: fitness in the upper bits, tag in the lower bits
   logic [EW-1:0] table_mem [POP_MAX];

   logic [1:0]                     state_ff, state_in;
   logic [PSIZE_BITS-1:0]          psize_ff, psize_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [CW-1:0]                  ptr_ff, ptr_in;
   logic                           rd_vld_ff, rd_vld_in;
   logic [AW-1:0]                  rd_idx_ff, rd_idx_in;
   logic [EW-1:0]                  rd_data_ff;
   logic signed [FITNESS_BITS-1:0] best_fit_ff, best_fit_in;
   logic [TAG_BITS-1:0]            best_tag_ff, best_tag_in;
   logic [AW-1:0]                  best_idx_ff, best_idx_in;
   logic signed [FITNESS_BITS-1:0] item_fit_ff, item_fit_in;
   logic [TAG_BITS-1:0]            item_tag_ff, item_tag_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_replaced_ff, rsp_replaced_in;
   logic [INDEX_BITS-1:0]          rsp_slot_ff, rsp_slot_in;
   logic [TAG_BITS-1:0]            rsp_tag_ff, rsp_tag_in;

   logic                           mem_we;
   logic [AW-1:0]                  mem_wa;
   logic [EW-1:0]                  mem_wd;
   logic                           req_fire;
   logic                           rsp_free;
   logic signed [FITNESS_BITS-1:0] rd_fit;
   logic [TAG_BITS-1:0]            rd_tag;
   logic [31:0]                    psize_ext;

   assign csr_ready       = 1'b1;
   assign rsp_free        = !rsp_valid_ff || rsp_ready;
   assign req_ready       = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire        = req_valid && req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_replaced    = rsp_replaced_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_evicted_tag = rsp_tag_ff;

   assign rd_fit    = rd_data_ff[EW-1:TAG_BITS];
   assign rd_tag    = rd_data_ff[TAG_BITS-1:0];
   assign psize_ext = 32'(psize_ff);

   // Table write port and registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= table_mem[ptr_ff[AW-1:0]];
   end

   // Sequencer and scan datapath
   always_comb begin
      state_in        = state_ff;
      psize_in        = psize_ff;
      count_in        = count_ff;
      ptr_in          = ptr_ff;
      rd_vld_in       = 1'b0;
      rd_idx_in       = rd_idx_ff;
      best_fit_in     = best_fit_ff;
      best_tag_in     = best_tag_ff;
      best_idx_in     = best_idx_ff;
      item_fit_in     = item_fit_ff;
      item_tag_in     = item_tag_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_replaced_in = rsp_replaced_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_tag_in      = rsp_tag_ff;
      mem_we          = 1'b0;
      mem_wa          = AW'(req_entry_index);
      mem_wd          = {req_fitness_value, req_member_tag};

      // take a configuration write
      if (csr_valid) begin
         psize_in = csr_population_size;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               item_fit_in = req_fitness_value;
               item_tag_in = req_member_tag;
               if (req_action == ACT_LOAD) begin
                  // write the entry and answer at once
                  mem_we          = (32'(req_entry_index) < 32'(POP_MAX));
                  rsp_valid_in    = 1'b1;
                  rsp_replaced_in = 1'b0;
                  rsp_slot_in     = req_entry_index;
                  rsp_tag_in      = '0;
               end else begin
                  // clamp the scan length to 1..POP_MAX
                  if (psize_ff == '0) begin
                     count_in = CW'(1);
                  end else if (psize_ext > 32'(POP_MAX)) begin
                     count_in = CW'(POP_MAX);
                  end else begin
                     count_in = CW'(psize_ff);
                  end
                  ptr_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // issue one read per cycle
            if (ptr_ff < count_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = ptr_ff[AW-1:0];
               ptr_in    = ptr_ff + CW'(1);
            end
            // compare the returning entry against the running minimum
            if (rd_vld_ff) begin
               if (rd_idx_ff == '0 || rd_fit < best_fit_ff) begin
                  best_fit_in = rd_fit;
                  best_tag_in = rd_tag;
                  best_idx_in = rd_idx_ff;
               end
               if (ptr_ff == count_ff) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            // replace the worst entry if the incomer beats it
            rsp_valid_in = 1'b1;
            rsp_slot_in  = INDEX_BITS'(best_idx_ff);
            mem_wa       = best_idx_ff;
            mem_wd       = {item_fit_ff, item_tag_ff};
            if (item_fit_ff > best_fit_ff) begin
               mem_we          = 1'b1;
               rsp_replaced_in = 1'b1;
               rsp_tag_in      = best_tag_ff;
            end else begin
               rsp_replaced_in = 1'b0;
               rsp_tag_in      = '0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         psize_ff     <= PSIZE_RESET;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         psize_ff     <= psize_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      count_ff        <= count_in;
      rd_idx_ff       <= rd_idx_in;
      best_fit_ff     <= best_fit_in;
      best_tag_ff     <= best_tag_in;
      best_idx_ff     <= best_idx_in;
      item_fit_ff     <= item_fit_in;
      item_tag_ff     <= item_tag_in;
      rsp_replaced_ff <= rsp_replaced_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_tag_ff      <= rsp_tag_in;
   end

endmodule

/* dv/replace_worst_population_slot_test.sv */
`timescale 1ns / 100ps

module replace_worst_population_slot_test;
   import rwps_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = POP_MAX_DEF + 8;
   localparam int PHASE_ITEMS  = 160;

   localparam logic signed [FITNESS_BITS_DEF-1:0] FIT_MIN = {1'b1, {(FITNESS_BITS_DEF-1){1'b0}}};
   localparam logic signed [FITNESS_BITS_DEF-1:0] FIT_MAX = {1'b0, {(FITNESS_BITS_DEF-1){1'b1}}};

   typedef struct {
      logic                    replaced;
      logic [INDEX_BITS-1:0]   slot;
      logic [TAG_BITS_DEF-1:0] evicted_tag;
   } placement_type;

   logic                               clock;
   logic                               reset;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [PSIZE_BITS-1:0]              csr_population_size;
   logic                               req_valid;
   logic                               req_ready;
   logic                               req_action;
   logic [INDEX_BITS-1:0]              req_entry_index;
   logic signed [FITNESS_BITS_DEF-1:0] req_fitness_value;
   logic [TAG_BITS_DEF-1:0]            req_member_tag;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic                               rsp_replaced;
   logic [INDEX_BITS-1:0]              rsp_slot;
   logic [TAG_BITS_DEF-1:0]            rsp_evicted_tag;

   // shadow copy of the population table and scan size
   logic signed [FITNESS_BITS_DEF-1:0] shadow_fitness [POP_MAX_DEF];
   logic [TAG_BITS_DEF-1:0]            shadow_tag [POP_MAX_DEF];
   logic [PSIZE_BITS-1:0]              shadow_size;

   placement_type pending_placements [$];
   int            failures;
   int            cycle_count;
   int            max_gap;

   replace_worst_population_slot i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_population_size (csr_population_size),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_entry_index     (req_entry_index),
      .req_fitness_value   (req_fitness_value),
      .req_member_tag      (req_member_tag),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_replaced        (rsp_replaced),
      .rsp_slot            (rsp_slot),
      .rsp_evicted_tag     (rsp_evicted_tag)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("replace_worst_population_slot: mismatch");
         $finish;
      end
   end

   // apply one transaction to the shadow table and return its placement
   function automatic placement_type resolve_placement(
      input logic                               act,
      input logic [INDEX_BITS-1:0]              idx,
      input logic signed [FITNESS_BITS_DEF-1:0] fit,
      input logic [TAG_BITS_DEF-1:0]            tag
   );
      placement_type res;
      int            span;
      int            worst;
      res.replaced    = 1'b0;
      res.slot        = idx;
      res.evicted_tag = '0;
      if (act == ACT_LOAD) begin
         shadow_fitness[idx] = fit;
         shadow_tag[idx]     = tag;
         return res;
      end
      // clamp the scan to 1..POP_MAX entries
      span = int'(shadow_size);
      if (span < 1) span = 1;
      if (span > POP_MAX_DEF) span = POP_MAX_DEF;
      worst = 0;
      for (int i = 1; i < span; i++) begin
         if (shadow_fitness[i] < shadow_fitness[worst]) worst = i;
      end
      res.slot = INDEX_BITS'(worst);
      if (fit > shadow_fitness[worst]) begin
         res.replaced          = 1'b1;
         res.evicted_tag       = shadow_tag[worst];
         shadow_fitness[worst] = fit;
         shadow_tag[worst]     = tag;
      end
      return res;
   endfunction

   // mix of tie-prone small values, full-range values and extremes
   function automatic logic signed [FITNESS_BITS_DEF-1:0] pick_fitness();
      int v;
      case ($urandom_range(0, 6))
         0, 1, 2: begin
            v = $urandom_range(0, 16);
            v = v - 8;
            return FITNESS_BITS_DEF'(v);
         end
         3, 4: return FITNESS_BITS_DEF'($urandom);
         5: return FIT_MIN;
         default: return FIT_MAX;
      endcase
   endfunction

   // send one request transaction; valid stays high afterwards until the next gap
   task automatic issue_request(
      input logic                               act,
      input logic [INDEX_BITS-1:0]              idx,
      input logic signed [FITNESS_BITS_DEF-1:0] fit,
      input logic [TAG_BITS_DEF-1:0]            tag
   );
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_entry_index   <= idx;
      req_fitness_value <= fit;
      req_member_tag    <= tag;
      do @(posedge clock); while (!req_ready);
      pending_placements.push_back(resolve_placement(act, idx, fit, tag));
   endtask

   // write the scan size once the block has drained
   task automatic write_population_size(input logic [PSIZE_BITS-1:0] size);
      req_valid <= 1'b0;
      while (pending_placements.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_valid           <= 1'b1;
      csr_population_size <= size;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      shadow_size = size;
   endtask

   // single-entry scan, equal and extreme fitness, then ties on a small table
   task automatic test_directed();
      max_gap = 15;
      write_population_size(7'd0);
      issue_request(ACT_LOAD, 6'd0, FIT_MIN, 16'hFFFF);
      issue_request(ACT_OFFER, 6'h2A, FIT_MIN, 16'h1234);
      issue_request(ACT_OFFER, 6'd0, FIT_MAX, 16'h0000);
      issue_request(ACT_OFFER, 6'h3F, FIT_MAX, 16'hBEEF);
      issue_request(ACT_LOAD, 6'd63, -24'sd1, 16'hA5A5);
      write_population_size(7'd4);
      issue_request(ACT_LOAD, 6'd1, 24'sd5, 16'h0001);
      issue_request(ACT_LOAD, 6'd2, 24'sd5, 16'h0002);
      issue_request(ACT_LOAD, 6'd3, 24'sd7, 16'h0003);
      issue_request(ACT_OFFER, 6'd0, 24'sd6, 16'h0011);
      issue_request(ACT_OFFER, 6'd0, 24'sd6, 16'h0012);
      issue_request(ACT_OFFER, 6'd0, 24'sd6, 16'h0013);
      issue_request(ACT_OFFER, 6'd0, -24'sd1, 16'h0014);
      issue_request(ACT_LOAD, 6'd3, FIT_MIN, 16'h5A5A);
      issue_request(ACT_OFFER, 6'd0, 24'sd0, 16'h0015);
   endtask

   // load every slot so that any scan size reads only written entries
   task automatic test_fill_table();
      write_population_size(7'd127);
      for (int i = 0; i < POP_MAX_DEF; i++) begin
         issue_request(ACT_LOAD, INDEX_BITS'(i), pick_fitness(), TAG_BITS_DEF'($urandom));
      end
   endtask

   // random loads and offers under one scan size
   task automatic test_random_traffic(input logic [PSIZE_BITS-1:0] size, input int gap_max);
      logic act;
      write_population_size(size);
      max_gap = gap_max;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         act = ($urandom_range(0, 9) < 4) ? ACT_LOAD : ACT_OFFER;
         issue_request(act, INDEX_BITS'($urandom), pick_fitness(), TAG_BITS_DEF'($urandom));
      end
   endtask

   // compare each response transaction with the oldest predicted placement
   initial begin
      placement_type want;
      int            stall;
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, max_gap);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_placements.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected response: replaced=%0b slot=%0d evicted=%h",
                        rsp_replaced, rsp_slot, rsp_evicted_tag);
         end else begin
            want = pending_placements.pop_front();
            if (rsp_replaced !== want.replaced || rsp_slot !== want.slot ||
                rsp_evicted_tag !== want.evicted_tag) begin
               failures++;
               if (failures <= 10)
                  $display("expected replaced=%0b slot=%0d evicted=%h, got %0b %0d %h",
                           want.replaced, want.slot, want.evicted_tag,
                           rsp_replaced, rsp_slot, rsp_evicted_tag);
            end
         end
      end
   end

   // reset, run the tests in turn, drain and report
   initial begin
      logic [PSIZE_BITS-1:0] phase_sizes [$];
      failures            = 0;
      cycle_count         = 0;
      max_gap             = 15;
      reset               <= 1'b1;
      csr_valid           <= 1'b0;
      csr_population_size <= '0;
      req_valid           <= 1'b0;
      req_action          <= ACT_LOAD;
      req_entry_index     <= '0;
      req_fitness_value   <= '0;
      req_member_tag      <= '0;
      for (int i = 0; i < POP_MAX_DEF; i++) begin
         shadow_fitness[i] = '0;
         shadow_tag[i]     = '0;
      end
      shadow_size = PSIZE_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_fill_table();
      phase_sizes = '{7'd127, 7'd64, 7'd1, 7'd0, 7'd2, 7'd63, 7'd65};
      repeat (3) phase_sizes.push_back(PSIZE_BITS'($urandom_range(0, 127)));
      foreach (phase_sizes[p])
         test_random_traffic(phase_sizes[p], (p % 3 == 2) ? 0 : 15);

      // drain outstanding responses
      req_valid <= 1'b0;
      while (pending_placements.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("replace_worst_population_slot: match");
      else
         $display("replace_worst_population_slot: mismatch");
      $finish;
   end

endmodule
